>>> rtl/mst_pkg.sv
// Package for the multi-slot deadline timer: table size, time width, result codes
// and the command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block uses it by scoped names.
package mst_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 32;
    localparam int IDX_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [15:0] TICK_STEP_RESET = 16'd1;

    // Request type of an input item.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Kind of a result item.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    // Add status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
    localparam logic [1:0] ST_ZERO_PERIOD = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the request; a tick advances time and restarts the scan
        logic add_commit; // store the timer and load the add status result
        logic scan_adv;   // process the current slot and step to the next one
        logic flush;      // hand out the held fire result as the last one
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_tick;   // request type at the input port
        logic out_free;   // output register can take a result this cycle
        logic hit;        // current slot is valid and due
        logic pend;       // a fire result is held back
        logic scan_last;  // current slot is the final one
    } t_sts;

endpackage

>>> rtl/mst_ctrl.sv
// Controller of the multi-slot deadline timer: sequences add and tick requests.
// Depends on mst_pkg for the command and status structs.
module mst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  mst_pkg::t_sts i_sts,
    output mst_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ADD   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.req_tick ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                // A due slot can only be taken once the held fire result has somewhere to go.
                if (!(i_sts.hit && i_sts.pend && !i_sts.out_free)) begin
                    o_cmd.scan_adv = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/mst_dp.sv
// Datapath of the multi-slot deadline timer: time counter, slot table, scan
// index, held fire result and output register. Depends on mst_pkg.
module mst_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mst_pkg::t_cmd i_cmd,
    output mst_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_req_type,
    input  logic [7:0]    i_msg_tag,
    input  logic [7:0]    i_dest_id,
    input  logic [31:0]   i_period,
    input  logic          i_periodic,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_kind,
    output logic [1:0]    o_status,
    output logic [7:0]    o_fired_tag,
    output logic [7:0]    o_fired_dest,
    output logic          o_last
);

    localparam int N  = mst_pkg::NUM_TIMERS;
    localparam int TB = mst_pkg::TIME_BITS;
    localparam int IB = mst_pkg::IDX_BITS;

    logic [15:0]   r_step;
    logic [TB-1:0] r_now;

    // Slot table.
    logic [N-1:0]  r_valid;
    logic [TB-1:0] r_deadline [N];
    logic [TB-1:0] r_period   [N];
    logic          r_repeat   [N];
    logic [7:0]    r_tag      [N];
    logic [7:0]    r_dest     [N];

    // Latched add request.
    logic [7:0]    r_req_tag;
    logic [7:0]    r_req_dest;
    logic [TB-1:0] r_req_period;
    logic          r_req_zero;
    logic          r_req_repeat;

    logic [IB-1:0] r_idx;
    logic          r_pend;
    logic [7:0]    r_pend_tag;
    logic [7:0]    r_pend_dest;

    logic          r_out_valid;
    logic          r_kind;
    logic [1:0]    r_status;
    logic [7:0]    r_tag_out;
    logic [7:0]    r_dest_out;
    logic          r_last;

    logic          out_free;
    logic [TB-1:0] cur_diff;
    logic          hit;
    logic          full;
    logic [IB-1:0] free_idx;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cur_diff = r_now - r_deadline[r_idx];
    assign hit      = r_valid[r_idx] && !cur_diff[TB-1];
    assign full     = &r_valid;

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = IB'(k);
            end
        end
    end

    assign o_sts.req_tick  = (i_req_type == mst_pkg::REQ_TICK);
    assign o_sts.out_free  = out_free;
    assign o_sts.hit       = hit;
    assign o_sts.pend      = r_pend;
    assign o_sts.scan_last = (r_idx == IB'(N - 1));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= mst_pkg::TICK_STEP_RESET;
            r_now       <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                if (i_req_type == mst_pkg::REQ_TICK) begin
                    r_now <= r_now + TB'(r_step);
                end
            end
            if (i_cmd.add_commit && !r_req_zero && !full) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.scan_adv) begin
                r_idx <= r_idx + 1'b1;
                if (hit) begin
                    r_pend <= 1'b1;
                    if (!r_repeat[r_idx]) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                end
            end
            if (i_cmd.flush) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.add_commit || i_cmd.flush || (i_cmd.scan_adv && hit && r_pend)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_tag    <= i_msg_tag;
            r_req_dest   <= i_dest_id;
            r_req_period <= TB'(i_period);
            r_req_zero   <= (i_period == 32'd0);
            r_req_repeat <= i_periodic;
        end
        if (i_cmd.add_commit && !r_req_zero && !full) begin
            r_deadline[free_idx] <= r_now + r_req_period;
            r_period[free_idx]   <= r_req_period;
            r_repeat[free_idx]   <= r_req_repeat;
            r_tag[free_idx]      <= r_req_tag;
            r_dest[free_idx]     <= r_req_dest;
        end
        if (i_cmd.scan_adv && hit) begin
            r_pend_tag  <= r_tag[r_idx];
            r_pend_dest <= r_dest[r_idx];
            if (r_repeat[r_idx]) begin
                r_deadline[r_idx] <= r_deadline[r_idx] + r_period[r_idx];
            end
        end
        if (i_cmd.add_commit) begin
            r_kind     <= mst_pkg::KIND_STATUS;
            r_tag_out  <= 8'd0;
            r_dest_out <= 8'd0;
            r_last     <= 1'b1;
            if (r_req_zero) begin
                r_status <= mst_pkg::ST_ZERO_PERIOD;
            end else if (full) begin
                r_status <= mst_pkg::ST_TABLE_FULL;
            end else begin
                r_status <= mst_pkg::ST_OK;
            end
        end else if (i_cmd.flush || (i_cmd.scan_adv && hit && r_pend)) begin
            // The held fire goes out; it is the last one only at the end of the scan.
            r_kind     <= mst_pkg::KIND_FIRE;
            r_status   <= mst_pkg::ST_OK;
            r_tag_out  <= r_pend_tag;
            r_dest_out <= r_pend_dest;
            r_last     <= i_cmd.flush;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_status     = r_status;
    assign o_fired_tag  = r_tag_out;
    assign o_fired_dest = r_dest_out;
    assign o_last       = r_last;

endmodule

>>> rtl/multi_slot_deadline_timer.sv
// Top level of the multi-slot deadline timer: joins the controller and the datapath.
// Depends on mst_pkg, mst_ctrl and mst_dp.
//
// Usage. The block keeps a table of 16 one-shot or periodic timers. An input item
// is accepted when i_in_valid is high and o_in_stall is low. An add item
// (i_req_type 0) stores a timer in the lowest free slot with deadline now + period
// and yields one status result: ok, table full, or zero period. A tick item
// (i_req_type 1) advances time by the tick step and yields one fire result for
// every valid timer whose deadline has been reached or passed (wrap-safe compare),
// in ascending slot order; o_last marks the final one. A tick with nothing due
// yields no result. Results leave through an output register, taken when
// o_out_valid is high and i_out_stall is low.
// Sequencing: one item is handled at a time. An add waits in S_ADD until the output
// register is free and then loads its status result. A tick walks the slot table
// one slot per cycle except while the scan waits at a due slot; each fire is held
// back until the next due slot or the end of the walk so that the last one can be
// flagged. A stalled receiver holds the output register, and the scan waits at a due
// slot until the held fire can be passed on. Reset (synchronous, active low) empties
// the table, clears time to zero and sets the tick step to 1. i_cfg_we writes the
// tick step; do so only while idle.
module multi_slot_deadline_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_msg_tag,
    input  logic [7:0]  i_dest_id,
    input  logic [31:0] i_period,
    input  logic        i_periodic,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_fired_tag,
    output logic [7:0]  o_fired_dest,
    output logic        o_last
);

    mst_pkg::t_cmd cmd;
    mst_pkg::t_sts sts;

    mst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_type   (i_req_type),
        .i_msg_tag    (i_msg_tag),
        .i_dest_id    (i_dest_id),
        .i_period     (i_period),
        .i_periodic   (i_periodic),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_status     (o_status),
        .o_fired_tag  (o_fired_tag),
        .o_fired_dest (o_fired_dest),
        .o_last       (o_last)
    );

endmodule
